// ----- rtl/core/flp_pkg.sv -----
package flp_pkg;

  localparam int unsigned NODE_W         = 10;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned ACTION_W       = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned POOL_NODES_DEF = 1024;
  localparam int unsigned CFG_RESET      = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESERVE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

endpackage

// ----- rtl/core/flp_req_if.sv -----
interface flp_req_if import flp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [NODE_W-1:0]   node;

  modport source (output valid, action, node, input ready);
  modport sink (input valid, action, node, output ready);
endinterface

// ----- rtl/core/flp_rsp_if.sv -----
interface flp_rsp_if import flp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   granted_node;
  logic [CFG_W-1:0]    capacity_now;

  modport source (output valid, status, granted_node, capacity_now, input ready);
  modport sink (input valid, status, granted_node, capacity_now, output ready);
endinterface

// ----- rtl/core/flp_ram.sv -----
module flp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/flp_core.sv -----
module flp_core import flp_pkg::*; #(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] init_capacity,
  flp_req_if.sink          req,
  flp_rsp_if.source        rsp
);

  localparam int unsigned IDX_W   = $clog2(POOL_NODES);
  localparam int unsigned CAP_W   = $clog2(POOL_NODES + 1);
  localparam int unsigned WORD_W  = IDX_W + 1;
  localparam int unsigned RST_CAP = (CFG_RESET > POOL_NODES) ? POOL_NODES : CFG_RESET;
  localparam logic [CAP_W:0] POOL_CAP = (CAP_W + 1)'(POOL_NODES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state;
  logic [ACTION_W-1:0] act;
  logic [NODE_W-1:0]   node_q;
  logic [IDX_W-1:0]    free_head, free_head_next;
  logic                head_valid, head_valid_next;
  logic [CAP_W-1:0]    fresh_next, fresh_next_next;
  logic [CAP_W-1:0]    pool_capacity, pool_capacity_next;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [NODE_W-1:0]   rsp_node;
  logic [CFG_W-1:0]    rsp_cap;

  logic                accept, slot_free, done;
  status_t             status_c;
  logic [CAP_W-1:0]    grant_c;
  logic [CAP_W-1:0]    fresh_base;
  logic [CAP_W:0]      cap_ext, grown;
  logic [31:0]         init_w, start_w, node_w, grant_w, cap_w;
  logic [CAP_W-1:0]    start_cap;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;
  assign done      = (state == S_EXEC) && slot_free;

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.granted_node = rsp_node;
  assign rsp.capacity_now = rsp_cap;

  // Restart capacity: zero means one, clip at the pool size
  always_comb begin
    init_w = 32'(init_capacity);
    if (init_w == 32'd0) begin
      start_w = 32'd1;
    end else if (init_w > POOL_NODES) begin
      start_w = POOL_NODES;
    end else begin
      start_w = init_w;
    end
    start_cap = start_w[CAP_W-1:0];
  end

  assign node_w  = 32'(node_q);
  assign cap_ext = {1'b0, pool_capacity};
  assign grown   = cap_ext + ((cap_ext + 1'b1) >> 1);

  always_comb begin
    free_head_next     = free_head;
    head_valid_next    = head_valid;
    fresh_next_next    = fresh_next;
    pool_capacity_next = pool_capacity;
    status_c           = ST_OK;
    grant_c            = '0;
    fresh_base         = fresh_next;
    mem_we             = 1'b0;
    mem_waddr          = node_w[IDX_W-1:0];
    mem_wdata          = {head_valid, free_head};
    case (act)
      ACT_RESERVE: begin
        if (head_valid) begin
          // pop: link of the head arrives from the read issued at accept
          grant_c         = CAP_W'(free_head);
          head_valid_next = mem_rdata[IDX_W];
          free_head_next  = mem_rdata[IDX_W-1:0];
          // drop the link mark of the popped node so a self loop ends
          mem_we          = 1'b1;
          mem_waddr       = free_head;
          mem_wdata       = {1'b0, mem_rdata[IDX_W-1:0]};
        end else begin
          if (fresh_next >= pool_capacity) begin
            if (cap_ext >= POOL_CAP) begin
              status_c = ST_EXHAUSTED;
            end else begin
              fresh_base = pool_capacity;
              if (grown > POOL_CAP) begin
                pool_capacity_next = POOL_CAP[CAP_W-1:0];
              end else begin
                pool_capacity_next = grown[CAP_W-1:0];
              end
            end
          end
          if (status_c == ST_OK) begin
            grant_c         = fresh_base;
            fresh_next_next = fresh_base + CAP_W'(1);
          end
        end
      end
      ACT_RELEASE: begin
        if (node_w >= 32'(pool_capacity)) begin
          status_c = ST_RANGE;
        end else begin
          mem_we          = 1'b1;
          free_head_next  = node_w[IDX_W-1:0];
          head_valid_next = 1'b1;
        end
      end
      ACT_RESTART: begin
        pool_capacity_next = start_cap;
        fresh_next_next    = '0;
        free_head_next     = '0;
        head_valid_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign grant_w = 32'(grant_c);
  assign cap_w   = 32'(pool_capacity_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_head     <= '0;
      head_valid    <= 1'b0;
      fresh_next    <= '0;
      pool_capacity <= CAP_W'(RST_CAP);
      rsp_valid     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the output register can take the result
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (done) begin
        free_head     <= free_head_next;
        head_valid    <= head_valid_next;
        fresh_next    <= fresh_next_next;
        pool_capacity <= pool_capacity_next;
        rsp_valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= req.action;
      node_q <= req.node;
    end
    if (done) begin
      rsp_status <= status_c;
      rsp_node   <= grant_w[NODE_W-1:0];
      rsp_cap    <= cap_w[CFG_W-1:0];
    end
  end

  flp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we && done),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (free_head),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/core/growing_free_list_node_pool.sv -----
// An accepted request is held in the S_EXEC state and then written to the output register;
// it stays in S_EXEC while the output side stalls.
// No new request is taken until the current one has left S_EXEC; each pop uses the read
// of the link memory issued at accept before the head can move.
// A request is taken while an earlier response still waits on the output side.
// Reset (synchronous, active high): free list empty, initial_capacity 8, capacity 8
// (clipped to the pool size); the link memory is not cleared.
module growing_free_list_node_pool import flp_pkg::*; #(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [CFG_W-1:0] wr_data,
  flp_req_if.sink          req,
  flp_rsp_if.source        rsp
);

  logic [CFG_W-1:0] initial_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_capacity <= CFG_W'(CFG_RESET);
    end else if (wr_en) begin
      initial_capacity <= wr_data;
    end
  end

  flp_core #(
    .POOL_NODES (POOL_NODES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .init_capacity (initial_capacity),
    .req           (req),
    .rsp           (rsp)
  );

endmodule

// ----- test/flp_pool_checker.sv -----
module flp_pool_checker import flp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [CFG_W-1:0] wr_data,
  flp_req_if               req,
  flp_rsp_if               rsp,
  output int unsigned      outstanding,
  output int unsigned      fail_count
);

  localparam int unsigned NODES = POOL_NODES_DEF;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node;
    logic [CFG_W-1:0]    capacity;
  } reply_t;

  logic [CFG_W-1:0]  start_cfg;
  logic [NODE_W-1:0] link_to [NODES];
  bit                link_live [NODES];
  logic [NODE_W-1:0] stack_top;
  bit                stack_live;
  int unsigned       fresh_next;
  int unsigned       capacity;
  int unsigned       errors;
  reply_t            expected_replies [$];

  function automatic void restart_pool();
    if (start_cfg == 0) begin
      capacity = 1;
    end else if (start_cfg > NODES) begin
      capacity = NODES;
    end else begin
      capacity = 32'(start_cfg);
    end
    fresh_next = 0;
    stack_top  = '0;
    stack_live = 1'b0;
  endfunction

  function automatic reply_t pool_step(input logic [ACTION_W-1:0] act,
                                       input logic [NODE_W-1:0] idx);
    reply_t            r;
    logic [NODE_W-1:0] taken;
    int unsigned       grown;
    r.status = ST_OK;
    r.node   = '0;
    case (act)
      ACT_RESERVE: begin
        if (stack_live) begin
          taken           = stack_top;
          r.node          = taken;
          stack_live      = link_live[taken];
          stack_top       = link_to[taken];
          link_live[taken] = 1'b0;
        end else begin
          if (fresh_next >= capacity) begin
            if (capacity >= NODES) begin
              r.status = ST_EXHAUSTED;
            end else begin
              // grow by half, rounded up, and hand out the new range in order
              grown      = capacity + ((capacity + 1) >> 1);
              fresh_next = capacity;
              capacity   = (grown > NODES) ? NODES : grown;
            end
          end
          if (r.status == ST_OK) begin
            r.node = fresh_next[NODE_W-1:0];
            fresh_next++;
          end
        end
      end
      ACT_RELEASE: begin
        if (idx >= capacity) begin
          r.status = ST_RANGE;
        end else begin
          link_to[idx]   = stack_top;
          link_live[idx] = stack_live;
          stack_top      = idx;
          stack_live     = 1'b1;
        end
      end
      ACT_RESTART: restart_pool();
      default: ;
    endcase
    r.capacity = capacity[CFG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      start_cfg = CFG_W'(CFG_RESET);
      for (int i = 0; i < NODES; i++) begin
        link_live[i] = 1'b0;
      end
      restart_pool();
      expected_replies.delete();
      errors = 0;
    end else begin
      if (wr_en) begin
        start_cfg = wr_data;
      end
      if (rsp.valid && rsp.ready) begin
        got.status   = rsp.status;
        got.node     = rsp.granted_node;
        got.capacity = rsp.capacity_now;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected response: status %0d node %0d capacity %0d",
                     got.status, got.node, got.capacity);
          end
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.node !== want.node ||
              got.capacity !== want.capacity) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (status/node/cap)",
                       want.status, want.node, want.capacity,
                       got.status, got.node, got.capacity);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_replies.push_back(pool_step(req.action, req.node));
      end
    end
    outstanding <= expected_replies.size();
    fail_count  <= errors;
  end

endmodule

// ----- test/tb_growing_free_list_node_pool.sv -----
module tb_growing_free_list_node_pool;
  import flp_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [CFG_W-1:0] wr_data;
  int unsigned      outstanding;
  int unsigned      fail_count;
  int unsigned      burst_left;

  flp_req_if req ();
  flp_rsp_if rsp ();

  growing_free_list_node_pool dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .req     (req),
    .rsp     (rsp)
  );

  flp_pool_checker pool_check (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .req         (req),
    .rsp         (rsp),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL growing_free_list_node_pool");
    $finish;
  end

  // response side: switch between always ready, coin flips and periodic stalls
  initial begin
    int unsigned stall_mode;
    int unsigned mode_left;
    stall_mode = 0;
    mode_left  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 1) == 1);
        default: rsp.ready <= ((mode_left % 8) < 3);
      endcase
    end
  end

  // hold the transaction until accepted; open a random gap (possibly none) before a new burst
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.node   <= idx;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_W-1:0] value);
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(input int unsigned count, input int unsigned reserve_pct,
                              input int unsigned span);
    int unsigned roll;
    logic [NODE_W-1:0] idx;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      idx  = NODE_W'($urandom());
      if (roll < 2) begin
        issue(ACT_UNUSED, idx);
      end else if (roll < 4) begin
        issue(ACT_RESTART, idx);
      end else if (roll < 4 + reserve_pct) begin
        issue(ACT_RESERVE, idx);
      end else begin
        // mostly nodes near the live range; otherwise anywhere
        if ($urandom_range(0, 3) != 0) begin
          idx = NODE_W'($urandom_range(0, span));
        end
        issue(ACT_RELEASE, idx);
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] value, input int unsigned count,
                           input int unsigned reserve_pct, input int unsigned span);
    settle();
    write_cfg(value);
    issue(ACT_RESTART, NODE_W'($urandom()));
    random_items(count, reserve_pct, span);
  endtask

  initial begin
    burst_left = 0;
    rst        <= 1'b1;
    wr_en      <= 1'b0;
    wr_data    <= '0;
    req.valid  <= 1'b0;
    req.action <= ACT_RESERVE;
    req.node   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default capacity of eight: drain it, grow, out-of-range and double release
    repeat (9) issue(ACT_RESERVE, '0);
    issue(ACT_RELEASE, 10'd0);
    issue(ACT_RELEASE, 10'd1023);
    issue(ACT_RELEASE, 10'd12);
    issue(ACT_RELEASE, 10'd11);
    issue(ACT_RESERVE, 10'd1023);
    issue(ACT_RESERVE, '0);
    issue(ACT_RELEASE, 10'd3);
    issue(ACT_RELEASE, 10'd3);
    issue(ACT_RESERVE, '0);
    issue(ACT_RESERVE, '0);
    issue(ACT_RESERVE, '0);
    issue(ACT_UNUSED, 10'd1023);
    issue(ACT_RESTART, '0);
    issue(ACT_RESERVE, '0);

    run_phase(11'd0, 15, 60, 16);
    run_phase(11'd1, 15, 55, 8);
    run_phase(11'd2, 15, 50, 8);
    run_phase(11'd5, 25, 60, 64);
    run_phase(11'($urandom_range(3, 40)), 25, 55, 128);
    run_phase(11'd1023, 10, 50, 1023);
    run_phase(11'd2047, 10, 50, 1023);

    // grow up to the pool size (clipped) and run dry
    settle();
    write_cfg(11'd700);
    issue(ACT_RESTART, '0);
    repeat (1026) issue(ACT_RESERVE, NODE_W'($urandom()));
    random_items(5, 40, 1023);

    run_phase(11'd1024, 5, 50, 1023);
    run_phase(11'd8, 15, 55, 16);

    settle();
    if (fail_count == 0) begin
      $display("PASS growing_free_list_node_pool");
    end else begin
      $display("FAIL growing_free_list_node_pool");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/flp_pkg.sv
rtl/core/flp_req_if.sv
rtl/core/flp_rsp_if.sv
rtl/core/flp_ram.sv
rtl/core/flp_core.sv
rtl/core/growing_free_list_node_pool.sv
test/flp_pool_checker.sv
test/tb_growing_free_list_node_pool.sv
